// ----- hw/rtl/stms_pkg.sv -----
// package for the scrolling text matrix scanner
// holds sizes, payload structs, micro-op codes and sequencer step numbers
// no dependencies
package stms_pkg;

    // display and storage sizes
    localparam int COLUMNS     = 30;
    localparam int ROWS        = 7;
    localparam int TEXT_DEPTH  = 32;
    localparam int GLYPH_WIDTH = 5;
    localparam int FIRST_CHAR  = 32;
    localparam int GLYPH_COUNT = 96;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_WIDTH;

    // widths: the first three derived from the sizes, the rest fixed
    localparam int TEXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int COL_W   = $clog2(GLYPH_WIDTH + 1);
    localparam int CNT_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ADDR_W  = 9;
    localparam int CHAR_W  = 7;
    localparam int ROW_W   = 3;
    localparam int SPEED_W = 8;
    localparam int LEN_W   = 6;
    localparam int CFG_W   = 8;

    // operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;
    localparam logic [1:0] OP_FONT = 2'd2;

    // register indexes
    localparam logic CFG_SPEED  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic [CHAR_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [COLUMNS-1:0] row_pattern;
        logic [ROW_W-1:0]   row_index;
    } t_result;

    // datapath micro-ops
    typedef enum logic [2:0] {
        A_NONE,
        A_TICK,
        A_LOAD,
        A_ISSUE,
        A_EMIT,
        A_WTEXT,
        A_WFONT,
        A_SCROLL
    } t_act;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_OP_TEXT,
        C_OP_FONT,
        C_OP_OTHER,
        C_SCROLL_HIT,
        C_MORE
    } t_cond;

    typedef logic [3:0] t_pc;

    // program steps
    localparam t_pc STEP_IDLE   = 4'd0;
    localparam t_pc STEP_DTEXT  = 4'd1;
    localparam t_pc STEP_DFONT  = 4'd2;
    localparam t_pc STEP_DOTHER = 4'd3;
    localparam t_pc STEP_TICK   = 4'd4;
    localparam t_pc STEP_CHECK  = 4'd5;
    localparam t_pc STEP_LOAD   = 4'd6;
    localparam t_pc STEP_RENDER = 4'd7;
    localparam t_pc STEP_DRAIN0 = 4'd8;
    localparam t_pc STEP_DRAIN1 = 4'd9;
    localparam t_pc STEP_EMIT   = 4'd10;
    localparam t_pc STEP_WTEXT  = 4'd11;
    localparam t_pc STEP_WFONT  = 4'd12;
    localparam t_pc STEP_SCROLL = 4'd13;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_act act;
        logic capture;
    } t_dp_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic op_text;
        logic op_font;
        logic op_other;
        logic scroll_hit;
        logic more;
    } t_dp_stat;

endpackage

// ----- hw/rtl/stms_sequencer.sv -----
// microcode sequencer: program rom, step counter and jump logic
// depends on stms_pkg
module stms_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  stms_pkg::t_dp_stat i_stat,
    output stms_pkg::t_dp_ctrl o_ctrl,
    output logic              o_busy
);

    stms_pkg::t_pc    r_pc;
    stms_pkg::t_pc    n_pc;
    stms_pkg::t_uword w_uword;
    logic             w_jump;

    // control store
    function automatic stms_pkg::t_uword rom(input stms_pkg::t_pc pc);
        stms_pkg::t_uword w;
        w = '{stms_pkg::A_NONE, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
        unique case (pc)
            stms_pkg::STEP_IDLE:
                w = '{stms_pkg::A_NONE, stms_pkg::C_NO_START, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_DTEXT:
                w = '{stms_pkg::A_NONE, stms_pkg::C_OP_TEXT, stms_pkg::STEP_WTEXT};
            stms_pkg::STEP_DFONT:
                w = '{stms_pkg::A_NONE, stms_pkg::C_OP_FONT, stms_pkg::STEP_WFONT};
            stms_pkg::STEP_DOTHER:
                w = '{stms_pkg::A_NONE, stms_pkg::C_OP_OTHER, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_TICK:
                w = '{stms_pkg::A_TICK, stms_pkg::C_NEXT, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_CHECK:
                w = '{stms_pkg::A_NONE, stms_pkg::C_SCROLL_HIT, stms_pkg::STEP_SCROLL};
            stms_pkg::STEP_LOAD:
                w = '{stms_pkg::A_LOAD, stms_pkg::C_NEXT, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_RENDER:
                w = '{stms_pkg::A_ISSUE, stms_pkg::C_MORE, stms_pkg::STEP_RENDER};
            stms_pkg::STEP_DRAIN0:
                w = '{stms_pkg::A_NONE, stms_pkg::C_NEXT, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_DRAIN1:
                w = '{stms_pkg::A_NONE, stms_pkg::C_NEXT, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_EMIT:
                w = '{stms_pkg::A_EMIT, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_WTEXT:
                w = '{stms_pkg::A_WTEXT, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_WFONT:
                w = '{stms_pkg::A_WFONT, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
            stms_pkg::STEP_SCROLL:
                w = '{stms_pkg::A_SCROLL, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
            default:
                w = '{stms_pkg::A_NONE, stms_pkg::C_ALWAYS, stms_pkg::STEP_IDLE};
        endcase
        return w;
    endfunction

    assign w_uword = rom(r_pc);
    assign o_busy  = (r_pc != stms_pkg::STEP_IDLE);

    // jump condition and next step
    always_comb begin
        unique case (w_uword.cond)
            stms_pkg::C_NEXT:       w_jump = 1'b0;
            stms_pkg::C_ALWAYS:     w_jump = 1'b1;
            stms_pkg::C_NO_START:   w_jump = !i_start;
            stms_pkg::C_OP_TEXT:    w_jump = i_stat.op_text;
            stms_pkg::C_OP_FONT:    w_jump = i_stat.op_font;
            stms_pkg::C_OP_OTHER:   w_jump = i_stat.op_other;
            stms_pkg::C_SCROLL_HIT: w_jump = i_stat.scroll_hit;
            stms_pkg::C_MORE:       w_jump = i_stat.more;
            default:                w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uword.target : r_pc + 4'd1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= stms_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // the idle step takes the command transfer
    assign o_ctrl.act     = w_uword.act;
    assign o_ctrl.capture = i_start && !o_busy;

endmodule

// ----- hw/rtl/stms_datapath.sv -----
// datapath: command latch, text and font memories, scroll state and row render pipe
// depends on stms_pkg
module stms_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stms_pkg::t_cmd     i_cmd,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [stms_pkg::CFG_W-1:0] i_cfg_wdata,
    input  stms_pkg::t_dp_ctrl i_ctrl,
    output stms_pkg::t_dp_stat o_stat,
    output stms_pkg::t_result  o_result,
    output logic               o_result_strobe
);

    localparam int POS_W = stms_pkg::TEXT_AW;
    localparam int AW    = stms_pkg::ADDR_W;
    localparam int CW    = stms_pkg::CHAR_W;

    // memories
    logic [CW-1:0] text_mem [stms_pkg::TEXT_DEPTH];
    logic [CW-1:0] font_mem [stms_pkg::FONT_DEPTH];

    stms_pkg::t_cmd r_cmd;

    logic [stms_pkg::SPEED_W-1:0] r_speed;
    logic [stms_pkg::LEN_W-1:0]   r_length;
    logic [stms_pkg::SPEED_W-1:0] r_tick;
    logic [POS_W-1:0]             r_scroll_char;
    logic [stms_pkg::COL_W-1:0]   r_scroll_col;
    logic [stms_pkg::ROW_W-1:0]   r_row;

    // render walk
    logic [POS_W-1:0]           r_pos;
    logic [stms_pkg::COL_W-1:0] r_col;
    logic [stms_pkg::CNT_W-1:0] r_cnt;

    // pipe: text read, font read, shift
    logic                       r_va;
    logic [stms_pkg::COL_W-1:0] r_col_a;
    logic [CW-1:0]              r_text_q;
    logic                       r_vb;
    logic                       r_blank_b;
    logic [CW-1:0]              r_font_q;
    logic [stms_pkg::COLUMNS-1:0] r_pattern;

    logic          w_blank;
    logic [AW-1:0] w_font_idx;
    logic [CW-1:0] w_glyph;
    logic [7:0]    w_font_ext;
    logic          w_bit;

    // next text position, wrapping at the used length or the buffer depth
    function automatic logic [POS_W-1:0] next_char(input logic [POS_W-1:0] pos,
                                                   input logic [stms_pkg::LEN_W-1:0] len);
        logic [POS_W:0] n;
        logic           wrap;
        n    = {1'b0, pos} + (POS_W+1)'(1);
        wrap = ((POS_W+1 > stms_pkg::LEN_W ? n : stms_pkg::LEN_W'(n)) >= len)
               || (n >= (POS_W+1)'(stms_pkg::TEXT_DEPTH));
        return wrap ? '0 : n[POS_W-1:0];
    endfunction

    // status for the sequencer
    assign o_stat.op_text    = (r_cmd.op == stms_pkg::OP_TEXT);
    assign o_stat.op_font    = (r_cmd.op == stms_pkg::OP_FONT);
    assign o_stat.op_other   = (r_cmd.op != stms_pkg::OP_TICK);
    assign o_stat.scroll_hit = (r_tick == r_speed);
    assign o_stat.more       = (r_cnt != stms_pkg::CNT_W'(stms_pkg::COLUMNS - 1));

    // command latch
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_cmd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= stms_pkg::SPEED_W'(100);
            r_length <= stms_pkg::LEN_W'(18);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stms_pkg::CFG_SPEED:  r_speed  <= i_cfg_wdata[stms_pkg::SPEED_W-1:0];
                stms_pkg::CFG_LENGTH: r_length <= i_cfg_wdata[stms_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // text and font writes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == stms_pkg::A_WTEXT &&
            r_cmd.address < AW'(stms_pkg::TEXT_DEPTH)) begin
            text_mem[r_cmd.address[POS_W-1:0]] <= r_cmd.value;
        end
        if (i_ctrl.act == stms_pkg::A_ISSUE) begin
            r_text_q <= text_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == stms_pkg::A_WFONT &&
            r_cmd.address < AW'(stms_pkg::FONT_DEPTH)) begin
            font_mem[r_cmd.address] <= r_cmd.value;
        end
        if (r_va) begin
            r_font_q <= font_mem[w_font_idx];
        end
    end

    // glyph lookup for the column in the middle pipe stage
    assign w_glyph    = r_text_q - CW'(stms_pkg::FIRST_CHAR);
    assign w_font_idx = AW'(w_glyph) * AW'(stms_pkg::GLYPH_WIDTH) + AW'(r_col_a);
    assign w_blank    = (r_col_a >= stms_pkg::COL_W'(stms_pkg::GLYPH_WIDTH))
                        || (r_text_q < CW'(stms_pkg::FIRST_CHAR));
    assign w_font_ext = {1'b0, r_font_q};
    assign w_bit      = !r_blank_b && w_font_ext[r_row];

    // scroll, tick and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_scroll_char <= '0;
            r_scroll_col  <= '0;
            r_row         <= '0;
        end else begin
            unique case (i_ctrl.act)
                stms_pkg::A_TICK: begin
                    r_tick <= r_tick + stms_pkg::SPEED_W'(1);
                end
                stms_pkg::A_SCROLL: begin
                    r_tick <= '0;
                    if (r_scroll_col >= stms_pkg::COL_W'(stms_pkg::GLYPH_WIDTH)) begin
                        r_scroll_col  <= '0;
                        r_scroll_char <= next_char(r_scroll_char, r_length);
                    end else begin
                        r_scroll_col <= r_scroll_col + stms_pkg::COL_W'(1);
                    end
                end
                stms_pkg::A_EMIT: begin
                    if (r_row >= stms_pkg::ROW_W'(stms_pkg::ROWS - 1)) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + stms_pkg::ROW_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // column walk across the row
    always_ff @(posedge i_clk) begin
        if (i_ctrl.act == stms_pkg::A_LOAD) begin
            r_pos <= r_scroll_char;
            r_col <= r_scroll_col;
            r_cnt <= '0;
        end else if (i_ctrl.act == stms_pkg::A_ISSUE) begin
            r_cnt   <= r_cnt + stms_pkg::CNT_W'(1);
            r_col_a <= r_col;
            if (r_col >= stms_pkg::COL_W'(stms_pkg::GLYPH_WIDTH)) begin
                r_col <= '0;
                r_pos <= next_char(r_pos, r_length);
            end else begin
                r_col <= r_col + stms_pkg::COL_W'(1);
            end
        end
    end

    // pipe valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= (i_ctrl.act == stms_pkg::A_ISSUE);
            r_vb <= r_va;
        end
    end

    // blank flag and pattern shift, column 0 ends up in bit 0
    always_ff @(posedge i_clk) begin
        if (r_va) begin
            r_blank_b <= w_blank;
        end
        if (r_vb) begin
            r_pattern <= {w_bit, r_pattern[stms_pkg::COLUMNS-1:1]};
        end
    end

    assign o_result.row_pattern = r_pattern;
    assign o_result.row_index   = r_row;
    assign o_result_strobe      = (i_ctrl.act == stms_pkg::A_EMIT);

endmodule

// ----- hw/rtl/scrolling_text_matrix_scanner.sv -----
// top level of the scrolling text matrix scanner
// depends on stms_pkg, stms_sequencer and stms_datapath
//
//  channel   ports                                   transfer
//  command   start, busy, i_cmd                      start high while busy low
//  result    o_result_strobe, o_result               strobe high, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata        i_cfg_we high
//
// text writes, font writes and unused codes go back to idle after decoding; a tick
// either scrolls or renders a row: the render loop fetches one column a cycle through
// the text memory then the font memory for all 30 columns, then drains the read pipe
// and gives the result strobe.
// reset is synchronous and active low; memories hold no reset contents.
// the receiver cannot stall: the result is shown for exactly one cycle.
module scrolling_text_matrix_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  stms_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [stms_pkg::CFG_W-1:0]     i_cfg_wdata,
    output stms_pkg::t_result              o_result,
    output logic                           o_result_strobe
);

    stms_pkg::t_dp_ctrl w_ctrl;
    stms_pkg::t_dp_stat w_stat;

    // program sequencer
    stms_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    // storage and render datapath
    stms_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule
